FILE: hdl/kfmm_pkg.sv
// ----------------------------------------------------------------------------
// kfmm_pkg
// Shared types and constants for the key frequency min/max table: request and
// response payloads, sequencer states, scan results and count clipping.
// ----------------------------------------------------------------------------
package kfmm_pkg;

    // Table geometry
    localparam int KEY_SLOTS  = 256;
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    typedef logic [KEY_BITS-1:0]   idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam idx_t   IDX_LAST  = idx_t'(KEY_SLOTS - 1);

    // Operation codes
    localparam logic OP_INC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Request payload
    typedef struct packed {
        logic       op;
        logic [7:0] key;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [7:0]  max_key;
        logic [15:0] max_count;
        logic [7:0]  min_key;
        logic [15:0] min_count;
        logic        table_empty;
        logic        rejected;
    } rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic acc;
        idx_t idx;
    } scan_ctl_t;

    // Running extremes kept by the scan unit
    typedef struct packed {
        logic   found;
        count_t max_c;
        idx_t   max_k;
        count_t min_c;
        idx_t   min_k;
    } scan_res_t;

    // Saturate a count to the 16-bit response field
    function automatic logic [15:0] clip16(input count_t c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

FILE: hdl/key_frequency_min_max_table.sv
// A new request is taken only in idle: busy is high from the taken request
// through the response. The wait is set by the scan of the count store,
// which reads one entry per cycle through its single read port.
// Reset clears all counts at once (per-entry valid bits) and returns to idle.
// The response is shown for exactly one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// key_frequency_min_max_table
// Per-key occurrence counter with increment/decrement requests. After each
// request the store is scanned to report the lowest key with the largest and
// with the smallest nonzero count.
// ----------------------------------------------------------------------------
module key_frequency_min_max_table
    import kfmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    state_t    state_reg,    state_next;
    idx_t      scan_idx_reg, scan_idx_next;
    idx_t      key_reg,      key_next;
    logic      op_reg,       op_next;
    logic      oor_reg,      oor_next;
    logic      rej_reg,      rej_next;
    logic      pend_reg;
    idx_t      pend_idx_reg;

    idx_t      rd_addr;
    count_t    rd_data;
    logic      wr_en;
    count_t    wr_data;
    scan_ctl_t scan_ctl;
    scan_res_t scan_res;

    kfmm_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (key_reg),
        .wr_data (wr_data)
    );

    kfmm_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .count (count_t'(rd_data)),
        .res   (scan_res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            key_reg      <= '0;
            op_reg       <= OP_INC;
            oor_reg      <= 1'b0;
            rej_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            key_reg      <= key_next;
            op_reg       <= op_next;
            oor_reg      <= oor_next;
            rej_reg      <= rej_next;
            pend_reg     <= (state_reg == ST_SCAN);
            pend_idx_reg <= scan_idx_reg;
        end
    end

    // Sequencer: read key, write back, scan, report
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        key_next      = key_reg;
        op_next       = op_reg;
        oor_next      = oor_reg;
        rej_next      = rej_reg;
        rd_addr       = scan_idx_reg;
        wr_en         = 1'b0;
        wr_data       = rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = idx_t'(req.key);
                if (start)
                begin
                    key_next   = idx_t'(req.key);
                    op_next    = req.op;
                    oor_next   = (32'(req.key) >= 32'(KEY_SLOTS));
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // read data of the key is here: modify and write back
                if (oor_reg)
                begin
                    rej_next = 1'b1;
                end
                else if (op_reg == OP_INC)
                begin
                    rej_next = (rd_data == COUNT_MAX);
                    wr_data  = rd_data + count_t'(1);
                end
                else
                begin
                    rej_next = (rd_data == '0);
                    wr_data  = rd_data - count_t'(1);
                end
                wr_en         = !rej_next;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + idx_t'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Scan unit control: clear at update, accumulate each returned read
    assign scan_ctl.clear = (state_reg == ST_UPDATE);
    assign scan_ctl.acc   = pend_reg;
    assign scan_ctl.idx   = pend_idx_reg;

    // Handshake and response
    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign rsp.max_key     = 8'(scan_res.max_k);
    assign rsp.max_count   = clip16(scan_res.max_c);
    assign rsp.min_key     = 8'(scan_res.min_k);
    assign rsp.min_count   = clip16(scan_res.min_c);
    assign rsp.table_empty = !scan_res.found;
    assign rsp.rejected    = rej_reg;

endmodule

FILE: hdl/kfmm_mem.sv
// ----------------------------------------------------------------------------
// kfmm_mem
// Count store: one write port, one read port with registered read data.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module kfmm_mem
    import kfmm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  idx_t   rd_addr,
    output count_t rd_data,
    input  logic   wr_en,
    input  idx_t   wr_addr,
    input  count_t wr_data
);

    count_t                 mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]   valid_reg;
    count_t                 rd_data_reg;
    logic                   rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits and read-side valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/kfmm_scan.sv
// ----------------------------------------------------------------------------
// kfmm_scan
// Running max/min tracker fed one count per cycle in ascending key order.
// Strict compares keep the lowest key id on ties; zero counts are skipped.
// ----------------------------------------------------------------------------
module kfmm_scan
    import kfmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_ctl_t ctl,
    input  count_t    count,
    output scan_res_t res
);

    scan_res_t res_reg;
    scan_res_t res_next;

    // Next extremes
    always_comb
    begin
        res_next = res_reg;
        if (ctl.clear)
        begin
            res_next = '0;
        end
        else if (ctl.acc && (count != '0))
        begin
            if (!res_reg.found)
            begin
                res_next.found = 1'b1;
                res_next.max_c = count;
                res_next.max_k = ctl.idx;
                res_next.min_c = count;
                res_next.min_k = ctl.idx;
            end
            else
            begin
                if (count > res_reg.max_c)
                begin
                    res_next.max_c = count;
                    res_next.max_k = ctl.idx;
                end
                if (count < res_reg.min_c)
                begin
                    res_next.min_c = count;
                    res_next.min_k = ctl.idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: hdl/kfmm_chk.sv
// ----------------------------------------------------------------------------
// kfmm_chk
// Port-level checks for the key frequency min/max table, bound to the top.
// ----------------------------------------------------------------------------
module kfmm_chk
    import kfmm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // A taken request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    // A response only appears while a request is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("response strobe while idle");

    // The block is free right after the response
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block not free after response");

    // Empty table reports zero counts
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.table_empty) |->
            (rsp.max_count == 16'd0 && rsp.min_count == 16'd0))
        else $error("empty table with nonzero count");

    // Non-empty table: max count at least min count, min nonzero
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.table_empty) |->
            (rsp.min_count != 16'd0 && rsp.max_count >= rsp.min_count))
        else $error("max/min counts out of order");

endmodule

bind key_frequency_min_max_table kfmm_chk u_kfmm_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key frequency min/max table. A short table of
// directed requests covers the empty table, rejected decrements, ties and
// the extreme key ids. Then random bursts grow and shrink a small pool of
// keys. Every response is compared field by field with the expected value of
// its directed row where given, else with a software tally of the table.
// ----------------------------------------------------------------------------
module tb_top;
    import kfmm_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int PHASE_LEN    = 60;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DIR_ROWS     = 24;
    localparam int PRINT_CAP    = 40;

    // One directed row: the expected response is filled in only when known
    typedef struct {
        logic       op;
        logic [7:0] key;
        bit         known;
        rsp_t       want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    count_t tally [KEY_SLOTS];
    rsp_t   pending_rsp [$];
    int     errors;
    int     cycles;
    int     burst_left;

    dir_row_t directed [DIR_ROWS] = '{
        // empty table, rejected decrement
        '{OP_DEC, 8'h00, 1'b1, '{8'h00, 16'd0, 8'h00, 16'd0, 1'b1, 1'b1}},
        '{OP_INC, 8'hFF, 1'b1, '{8'hFF, 16'd1, 8'hFF, 16'd1, 1'b0, 1'b0}},
        // tie at count one goes to the lower key
        '{OP_INC, 8'h00, 1'b1, '{8'h00, 16'd1, 8'h00, 16'd1, 1'b0, 1'b0}},
        '{OP_INC, 8'h00, 1'b1, '{8'h00, 16'd2, 8'hFF, 16'd1, 1'b0, 1'b0}},
        // absent key in a non-empty table
        '{OP_DEC, 8'h80, 1'b1, '{8'h00, 16'd2, 8'hFF, 16'd1, 1'b0, 1'b1}},
        '{OP_DEC, 8'hFF, 1'b1, '{8'h00, 16'd2, 8'h00, 16'd2, 1'b0, 1'b0}},
        '{OP_DEC, 8'h00, 1'b1, '{8'h00, 16'd1, 8'h00, 16'd1, 1'b0, 1'b0}},
        // back to empty, then reject again
        '{OP_DEC, 8'h00, 1'b1, '{8'h00, 16'd0, 8'h00, 16'd0, 1'b1, 1'b0}},
        '{OP_DEC, 8'h00, 1'b1, '{8'h00, 16'd0, 8'h00, 16'd0, 1'b1, 1'b1}},
        '{OP_INC, 8'h55, 1'b0, '0},
        '{OP_INC, 8'hAA, 1'b0, '0},
        '{OP_INC, 8'hAA, 1'b0, '0},
        '{OP_INC, 8'h01, 1'b0, '0},
        '{OP_INC, 8'h80, 1'b0, '0},
        '{OP_INC, 8'h80, 1'b0, '0},
        '{OP_INC, 8'h80, 1'b0, '0},
        '{OP_DEC, 8'hAA, 1'b0, '0},
        '{OP_INC, 8'hFE, 1'b0, '0},
        '{OP_DEC, 8'h7F, 1'b0, '0},
        '{OP_DEC, 8'h55, 1'b0, '0},
        '{OP_DEC, 8'h01, 1'b0, '0},
        '{OP_DEC, 8'hFE, 1'b0, '0},
        '{OP_DEC, 8'h80, 1'b0, '0},
        '{OP_INC, 8'h7F, 1'b0, '0}
    };

    key_frequency_min_max_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one request to the tally and work out the response it produces
    function automatic rsp_t key_tally(input logic op, input logic [7:0] key);
        rsp_t   r;
        logic   hit;
        count_t c;
        count_t hi_c;
        count_t lo_c;
        int     i;
        r    = '0;
        hit  = 1'b0;
        hi_c = '0;
        lo_c = '0;
        if (int'(key) >= KEY_SLOTS)
            r.rejected = 1'b1;
        else if (op == OP_INC)
        begin
            if (tally[key] == COUNT_MAX)
                r.rejected = 1'b1;
            else
                tally[key] = tally[key] + 1'b1;
        end
        else
        begin
            if (tally[key] == '0)
                r.rejected = 1'b1;
            else
                tally[key] = tally[key] - 1'b1;
        end
        // strict compares keep the lowest key on ties
        for (i = 0; i < KEY_SLOTS; i++)
        begin
            c = tally[i];
            if (c != '0)
            begin
                if (!hit || c > hi_c)
                begin
                    hi_c      = c;
                    r.max_key = 8'(i);
                end
                if (!hit || c < lo_c)
                begin
                    lo_c      = c;
                    r.min_key = 8'(i);
                end
                hit = 1'b1;
            end
        end
        r.max_count   = (32'(hi_c) > 32'hFFFF) ? 16'hFFFF : 16'(hi_c);
        r.min_count   = (32'(lo_c) > 32'hFFFF) ? 16'hFFFF : 16'(lo_c);
        r.table_empty = !hit;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("tb_top: mismatch %s got %0h exp %0h at cycle %0d",
                     what, got, want, cycles);
    endtask

    // Hold the request until it is taken, log the expected response, then
    // idle for a random gap (bursts of back-to-back requests in between)
    task automatic send_request(input logic op, input logic [7:0] key,
                                input bit known, input rsp_t want);
        rsp_t predicted;
        int   gap;
        start   <= 1'b1;
        req.op  <= op;
        req.key <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = key_tally(op, key);
        pending_rsp.push_back(known ? want : predicted);
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 320)
                                               : $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            req   <= req_t'($urandom);
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Response checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected response", 32'(rsp), 32'd0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.max_key !== want.max_key)
                    report("max_key", 32'(rsp.max_key), 32'(want.max_key));
                if (rsp.max_count !== want.max_count)
                    report("max_count", 32'(rsp.max_count),
                           32'(want.max_count));
                if (rsp.min_key !== want.min_key)
                    report("min_key", 32'(rsp.min_key), 32'(want.min_key));
                if (rsp.min_count !== want.min_count)
                    report("min_count", 32'(rsp.min_count),
                           32'(want.min_count));
                if (rsp.table_empty !== want.table_empty)
                    report("table_empty", 32'(rsp.table_empty),
                           32'(want.table_empty));
                if (rsp.rejected !== want.rejected)
                    report("rejected", 32'(rsp.rejected),
                           32'(want.rejected));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stim
        int         n;
        int         dec_pct;
        logic [7:0] pool_base;
        logic [7:0] key;
        logic       op;
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        dec_pct    = 70;
        pool_base  = '0;
        for (n = 0; n < KEY_SLOTS; n++)
            tally[n] = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (n = 0; n < DIR_ROWS; n++)
            send_request(directed[n].op, directed[n].key, directed[n].known,
                         directed[n].want);

        // random phases: grow a fresh pool of eight keys, then shrink it
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                if (dec_pct == 70)
                begin
                    dec_pct   = 25;
                    pool_base = 8'($urandom);
                end
                else
                    dec_pct = 70;
            end
            if ($urandom_range(0, 99) < 80)
                key = pool_base + 8'($urandom_range(0, 7));
            else
                key = 8'($urandom);
            op = ($urandom_range(0, 99) < dec_pct) ? OP_DEC : OP_INC;
            send_request(op, key, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/kfmm_pkg.sv
hdl/kfmm_mem.sv
hdl/kfmm_scan.sv
hdl/key_frequency_min_max_table.sv
hdl/kfmm_chk.sv
sim/tb_top.sv
